FILE: hdl/rmeu_pkg.sv
// Package for the register machine execute unit.
// Holds shared types, command and error codes and constants; no dependencies.
package rmeu_pkg;

   localparam int DEF_STACK_DEPTH = 64;
   localparam int DEF_REG_COUNT   = 32;
   localparam int DATA_W          = 32;
   localparam int INDEX_W         = 5;
   localparam int STATUS_ENTRIES  = 8;

   localparam int FLAG_PARITY   = 0;
   localparam int FLAG_ZERO     = 1;
   localparam int FLAG_SIGN     = 2;
   localparam int FLAG_OVERFLOW = 5;

   localparam logic [1:0] STATUS_RESET = 2'd2;
   localparam logic [DATA_W-1:0] LOW_NIBBLE_MASK  = 32'd15;
   localparam logic [DATA_W-1:0] HIGH_NIBBLE_MASK = 32'd240;

   typedef enum logic [4:0] {
      CMD_ADD    = 5'd0,
      CMD_SUB    = 5'd1,
      CMD_AND    = 5'd2,
      CMD_XOR    = 5'd3,
      CMD_OR     = 5'd4,
      CMD_ADDI   = 5'd5,
      CMD_SUBI   = 5'd6,
      CMD_ANDI   = 5'd7,
      CMD_XORI   = 5'd8,
      CMD_ORI    = 5'd9,
      CMD_MOVI   = 5'd10,
      CMD_MOVR   = 5'd11,
      CMD_SWAP   = 5'd12,
      CMD_DIV    = 5'd13,
      CMD_MULL   = 5'd14,
      CMD_PUSH   = 5'd15,
      CMD_POP    = 5'd16,
      CMD_INPUT  = 5'd17,
      CMD_OUTPUT = 5'd18,
      CMD_SKIPEQ = 5'd19
   } cmd_type;

   typedef enum logic [1:0] {
      ERR_OK       = 2'd0,
      ERR_DIV_ZERO = 2'd1,
      ERR_UNKNOWN  = 2'd2
   } err_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WAIT,
      ST_WRB,
      ST_POPW,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_RUN,
      MD_FIX
   } md_state_type;

   typedef struct packed {
      logic              start;
      logic              is_div;
      logic [DATA_W-1:0] op_a;
      logic [DATA_W-1:0] op_b;
   } md_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] lo;   // quotient or product bits 31:0
      logic [DATA_W-1:0] hi;   // remainder or product bits 63:32
   } md_res_type;

endpackage

FILE: hdl/rmeu_regfile.sv
// Register file of the execute unit: one write port, two registered read ports.
// Per-entry valid bits make unwritten registers read as zero. Uses rmeu_pkg.
module rmeu_regfile
   import rmeu_pkg::*;
#(
   parameter int REG_COUNT = DEF_REG_COUNT,
   localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [RW-1:0]     rd_a_addr,
   input  logic [RW-1:0]     rd_b_addr,
   output logic [DATA_W-1:0] rd_a_data,
   output logic [DATA_W-1:0] rd_b_data,
   input  logic              wr_en,
   input  logic [RW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff;
   logic [DATA_W-1:0] rd_a_ff, rd_b_ff;
   logic vld_a_ff, vld_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         vld_a_ff <= valid_ff[rd_a_addr];
         vld_b_ff <= valid_ff[rd_b_addr];
      end
   end

   assign rd_a_data = vld_a_ff ? rd_a_ff : '0;
   assign rd_b_data = vld_b_ff ? rd_b_ff : '0;

endmodule

FILE: hdl/rmeu_stack.sv
// Status stack: a memory of 2-bit entries with a wrapping top pointer and a
// saturating fill count. Pop data is registered. Uses rmeu_pkg.
module rmeu_stack
   import rmeu_pkg::*;
#(
   parameter int STACK_DEPTH = DEF_STACK_DEPTH,
   localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
   localparam int CW = $clog2(STACK_DEPTH + 1)
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic [1:0] push_data,
   input  logic       pop,
   output logic       empty,
   output logic [1:0] pop_data
);

   logic [1:0] mem [STACK_DEPTH];
   logic [SW-1:0] top_ff, top_in, top_dec;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0] pop_data_ff;

   assign top_dec = (top_ff == '0) ? SW'(STACK_DEPTH - 1) : top_ff - 1'b1;
   assign empty   = (count_ff == '0);

   always_comb begin
      top_in   = top_ff;
      count_in = count_ff;
      if (push) begin
         top_in = (top_ff == SW'(STACK_DEPTH - 1)) ? '0 : top_ff + 1'b1;
         if (count_ff != CW'(STACK_DEPTH)) begin
            count_in = count_ff + 1'b1;
         end
      end else if (pop && !empty) begin
         top_in   = top_dec;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff   <= '0;
         count_ff <= '0;
      end else begin
         top_ff   <= top_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[top_ff] <= push_data;
      end
      pop_data_ff <= mem[top_dec];
   end

   assign pop_data = pop_data_ff;

endmodule

FILE: hdl/rmeu_muldiv.sv
// Iterative signed multiply and truncating divide on magnitudes, one bit per
// cycle through a single shared 33-bit adder, then a sign fix step. Uses rmeu_pkg.
module rmeu_muldiv
   import rmeu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  md_req_type req,
   output md_res_type res
);

   md_state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic is_div_ff, is_div_in;
   logic neg_lo_ff, neg_lo_in, neg_hi_ff, neg_hi_in;
   logic [DATA_W-1:0] x_ff, x_in, y_ff, y_in, m_ff, m_in;
   md_res_type res_ff, res_in;

   logic [DATA_W:0] op1, op2;
   logic cin;
   logic [DATA_W+1:0] sum;
   logic [2*DATA_W-1:0] prod;

   // Shared adder: accumulate for multiply, trial subtract for divide.
   always_comb begin
      if (is_div_ff) begin
         op1 = {x_ff, y_ff[DATA_W-1]};
         op2 = ~{1'b0, m_ff};
         cin = 1'b1;
      end else begin
         op1 = {1'b0, x_ff};
         op2 = y_ff[0] ? {1'b0, m_ff} : '0;
         cin = 1'b0;
      end
      sum = {1'b0, op1} + {1'b0, op2} + {{(DATA_W+1){1'b0}}, cin};
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      is_div_in = is_div_ff;
      neg_lo_in = neg_lo_ff;
      neg_hi_in = neg_hi_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      m_in      = m_ff;
      res_in    = res_ff;
      res_in.done = 1'b0;
      prod      = {x_ff, y_ff};
      unique case (state_ff)
         MD_IDLE: begin
            if (req.start) begin
               state_in  = MD_RUN;
               cnt_in    = '0;
               is_div_in = req.is_div;
               neg_lo_in = req.op_a[DATA_W-1] ^ req.op_b[DATA_W-1];
               neg_hi_in = req.is_div ? req.op_a[DATA_W-1]
                                      : req.op_a[DATA_W-1] ^ req.op_b[DATA_W-1];
               x_in = '0;
               y_in = req.op_a[DATA_W-1] ? -req.op_a : req.op_a;
               m_in = req.op_b[DATA_W-1] ? -req.op_b : req.op_b;
            end
         end
         MD_RUN: begin
            if (is_div_ff) begin
               if (sum[DATA_W+1]) begin
                  x_in = sum[DATA_W-1:0];
               end else begin
                  x_in = {x_ff[DATA_W-2:0], y_ff[DATA_W-1]};
               end
               y_in = {y_ff[DATA_W-2:0], sum[DATA_W+1]};
            end else begin
               x_in = sum[DATA_W:1];
               y_in = {sum[0], y_ff[DATA_W-1:1]};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd31) begin
               state_in = MD_FIX;
            end
         end
         MD_FIX: begin
            state_in    = MD_IDLE;
            res_in.done = 1'b1;
            if (is_div_ff) begin
               res_in.lo = neg_lo_ff ? -y_ff : y_ff;
               res_in.hi = neg_hi_ff ? -x_ff : x_ff;
            end else begin
               prod      = neg_lo_ff ? -{x_ff, y_ff} : {x_ff, y_ff};
               res_in.lo = prod[DATA_W-1:0];
               res_in.hi = prod[2*DATA_W-1:DATA_W];
            end
         end
         default: state_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= MD_IDLE;
         res_ff.done <= 1'b0;
      end else begin
         state_ff    <= state_in;
         res_ff.done <= res_in.done;
      end
      cnt_ff    <= cnt_in;
      is_div_ff <= is_div_in;
      neg_lo_ff <= neg_lo_in;
      neg_hi_ff <= neg_hi_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      m_ff      <= m_in;
      res_ff.lo <= res_in.lo;
      res_ff.hi <= res_in.hi;
   end

   assign res = res_ff;

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> state_ff == MD_IDLE)
      else $error("muldiv started while busy");

   a_done_after_fix: assert property (@(posedge clock) disable iff (reset)
      state_ff == MD_FIX |=> res.done)
      else $error("muldiv done missing after fix cycle");

   a_run_after_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == MD_IDLE && req.start) |=> state_ff == MD_RUN && cnt_ff == '0)
      else $error("muldiv did not begin iterating");

endmodule

FILE: hdl/register_machine_execute_unit.sv
// Register machine execute unit: executes one instruction per input beat.
// Input channel req_*: one instruction per beat; the opcode travels on req_tuser.
// Result channel rsp_*: exactly one result beat per instruction, in order.
// The unit takes one instruction at a time. req_tready is high only while it
// waits for an instruction. After acceptance, ALU, move, input, output, push
// and compare instructions pass through read, execute and result register;
// pop from a non-empty stack and swap add a stack read or a second register
// write, and divide and multiply wait on the shared multiply/divide unit
// (a divide by zero does not start it), which resolves one bit of the 32-bit
// operands per cycle, followed by a sign correction and two register file writes.
// A further instruction is taken as soon as the previous one has moved into
// the result register, even while that beat waits on rsp_tready; a second
// result then waits until the first beat is taken.
// Reset (synchronous, active high) clears all registers to zero, all status
// entries to two and empties the status stack; no clearing pass is needed.
// Uses rmeu_pkg, rmeu_regfile, rmeu_stack and rmeu_muldiv.
module register_machine_execute_unit
   import rmeu_pkg::*;
#(
   parameter int STACK_DEPTH = DEF_STACK_DEPTH,
   parameter int REG_COUNT   = DEF_REG_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // dest_index[4:0], src_a_index[9:5], src_b_index[14:10], immediate[46:15],
   // input_value[78:47], flag_index[81:79], zero fill above
   input  logic [87:0] req_tdata,
   // command[4:0]
   input  logic [4:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // value[31:0], status_word[47:32], skip_next[48], error_code[50:49], zero fill above
   output logic [55:0] rsp_tdata
);

   localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

   state_type state_ff, state_in;
   cmd_type cmd_ff;
   logic [RW-1:0] d_ff, ia_ff, ib_ff;
   logic [DATA_W-1:0] imm_ff, inval_ff;
   logic [2:0] fi_ff;
   logic [1:0] status_ff [STATUS_ENTRIES];
   logic [1:0] status_in [STATUS_ENTRIES];
   logic [DATA_W-1:0] value_ff, value_in, sec_ff, sec_in;
   logic skip_ff, skip_in;
   err_type err_ff, err_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [55:0] rsp_data_ff, rsp_data_in;

   logic [RW-1:0] reg_mod [32];
   logic [RW-1:0] rd_a_addr, rd_b_addr, wr_addr;
   logic [DATA_W-1:0] rd_a_data, rd_b_data, wr_data;
   logic wr_en;
   logic [DATA_W-1:0] op_a, op_b, alu_b, sum, logic_r;
   logic is_sub, add_ovf, sub_ovf;
   logic push, pop, stack_empty;
   logic [1:0] pop_data;
   md_req_type md_req;
   md_res_type md_res;
   logic [15:0] status_word;
   logic accept;

   // Register numbers are taken modulo the register count through a constant table.
   for (genvar k = 0; k < 32; k++) begin : g_mod
      assign reg_mod[k] = RW'(k % REG_COUNT);
   end

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rd_a_addr  = (cmd_type'(req_tuser) == CMD_OUTPUT) ? '0 : reg_mod[req_tdata[9:5]];
   assign rd_b_addr  = reg_mod[req_tdata[14:10]];

   rmeu_regfile #(.REG_COUNT(REG_COUNT)) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   rmeu_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (status_ff[fi_ff]),
      .pop       (pop),
      .empty     (stack_empty),
      .pop_data  (pop_data)
   );

   rmeu_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .req   (md_req),
      .res   (md_res)
   );

   // Operand b is the immediate for the immediate forms of the ALU commands.
   assign op_a = rd_a_data;
   assign op_b = (cmd_ff >= CMD_ADDI && cmd_ff <= CMD_ORI) ? imm_ff : rd_b_data;
   assign is_sub = (cmd_ff == CMD_SUB) || (cmd_ff == CMD_SUBI);
   assign alu_b  = is_sub ? ~op_b : op_b;
   assign sum    = op_a + alu_b + {{(DATA_W-1){1'b0}}, is_sub};
   assign add_ovf = (!op_a[31] && op_a != '0 && !op_b[31] && op_b != '0 && sum[31]) ||
                    (op_a[31] && op_b[31] && !sum[31] && sum != '0);
   assign sub_ovf = (!op_a[31] && op_a != '0 && op_b[31] && sum[31]) ||
                    (op_a[31] && !op_b[31] && op_b != '0 && !sum[31] && sum != '0);

   always_comb begin
      unique case (cmd_ff)
         CMD_AND, CMD_ANDI: logic_r = op_a & op_b;
         CMD_XOR, CMD_XORI: logic_r = op_a ^ op_b;
         default:           logic_r = op_a | op_b;
      endcase
   end

   always_comb begin
      for (int i = 0; i < STATUS_ENTRIES; i++) begin
         status_word[2*i +: 2] = status_ff[i];
      end
   end

   always_comb begin
      logic [DATA_W-1:0] r;
      logic [DATA_W-1:0] p;
      state_in     = state_ff;
      status_in    = status_ff;
      value_in     = value_ff;
      sec_in       = sec_ff;
      skip_in      = skip_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = ia_ff;
      wr_data      = '0;
      push         = 1'b0;
      pop          = 1'b0;
      md_req       = '0;
      md_req.op_a  = op_a;
      md_req.op_b  = op_b;
      r            = '0;
      p            = md_res.lo;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
               value_in = '0;
               skip_in  = 1'b0;
               err_in   = ERR_OK;
            end
         end
         ST_EXEC: begin
            state_in = ST_FINISH;
            unique case (cmd_ff)
               CMD_ADD, CMD_SUB, CMD_AND, CMD_XOR, CMD_OR,
               CMD_ADDI, CMD_SUBI, CMD_ANDI, CMD_XORI, CMD_ORI: begin
                  r = (cmd_ff == CMD_ADD || cmd_ff == CMD_SUB || cmd_ff == CMD_ADDI ||
                       cmd_ff == CMD_SUBI) ? sum : logic_r;
                  wr_en    = 1'b1;
                  wr_addr  = d_ff;
                  wr_data  = r;
                  value_in = r;
                  status_in[FLAG_PARITY] = {1'b0, !r[31] && ^r};
                  status_in[FLAG_ZERO]   = {1'b0, r == '0};
                  status_in[FLAG_SIGN]   = {1'b0, r[31]};
                  if (cmd_ff == CMD_ADD || cmd_ff == CMD_ADDI) begin
                     status_in[FLAG_OVERFLOW] = {1'b0, add_ovf};
                  end else if (is_sub) begin
                     status_in[FLAG_OVERFLOW] = {1'b0, sub_ovf};
                  end
               end
               CMD_MOVI: begin
                  wr_en    = 1'b1;
                  wr_addr  = d_ff;
                  wr_data  = imm_ff;
                  value_in = imm_ff;
               end
               CMD_MOVR: begin
                  wr_en    = 1'b1;
                  wr_addr  = d_ff;
                  wr_data  = op_a;
                  value_in = op_a;
               end
               CMD_SWAP: begin
                  // When both indexes match, the later write of a decides the value.
                  wr_en    = 1'b1;
                  wr_data  = op_b;
                  sec_in   = op_a;
                  value_in = (ia_ff == ib_ff) ? op_a : op_b;
                  state_in = ST_WRB;
               end
               CMD_DIV: begin
                  if (op_b == '0) begin
                     err_in = ERR_DIV_ZERO;
                  end else begin
                     md_req.start  = 1'b1;
                     md_req.is_div = 1'b1;
                     state_in      = ST_WAIT;
                  end
               end
               CMD_MULL: begin
                  md_req.start = 1'b1;
                  state_in     = ST_WAIT;
               end
               CMD_PUSH: push = 1'b1;
               CMD_POP: begin
                  if (stack_empty) begin
                     status_in[fi_ff] = 2'd0;
                  end else begin
                     pop      = 1'b1;
                     state_in = ST_POPW;
                  end
               end
               CMD_INPUT: begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = inval_ff;
                  value_in = inval_ff;
               end
               CMD_OUTPUT: value_in = op_a;
               CMD_SKIPEQ: skip_in = (op_a == rd_b_data);
               default: err_in = ERR_UNKNOWN;
            endcase
         end
         ST_WAIT: begin
            if (md_res.done) begin
               state_in = ST_WRB;
               wr_en    = 1'b1;
               if (cmd_ff == CMD_DIV) begin
                  r        = md_res.lo;
                  wr_data  = md_res.lo;
                  value_in = md_res.lo;
                  sec_in   = md_res.hi;
               end else begin
                  r        = p;
                  wr_data  = (p & HIGH_NIBBLE_MASK) >> 4;
                  sec_in   = p & LOW_NIBBLE_MASK;
                  value_in = (ia_ff == ib_ff) ? (p & LOW_NIBBLE_MASK)
                                              : ((p & HIGH_NIBBLE_MASK) >> 4);
                  status_in[FLAG_OVERFLOW] = {1'b0, md_res.hi != {DATA_W{p[31]}}};
               end
               status_in[FLAG_PARITY] = {1'b0, !r[31] && ^r};
               status_in[FLAG_ZERO]   = {1'b0, r == '0};
               status_in[FLAG_SIGN]   = {1'b0, r[31]};
            end
         end
         ST_WRB: begin
            wr_en    = 1'b1;
            wr_addr  = ib_ff;
            wr_data  = sec_ff;
            state_in = ST_FINISH;
         end
         ST_POPW: begin
            status_in[fi_ff] = pop_data;
            state_in         = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, err_ff, skip_ff, status_word, value_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < STATUS_ENTRIES; i++) begin
            status_ff[i] <= STATUS_RESET;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= cmd_type'(req_tuser);
         d_ff     <= reg_mod[req_tdata[4:0]];
         ia_ff    <= reg_mod[req_tdata[9:5]];
         ib_ff    <= reg_mod[req_tdata[14:10]];
         imm_ff   <= req_tdata[46:15];
         inval_ff <= req_tdata[78:47];
         fi_ff    <= req_tdata[81:79];
      end
      value_ff    <= value_in;
      sec_ff      <= sec_in;
      skip_ff     <= skip_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_exec_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_EXEC)
      else $error("accepted beat not executed next cycle");

   a_md_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      md_res.done |-> state_ff == ST_WAIT)
      else $error("multiply/divide result outside wait state");

   a_no_push_and_pop: assert property (@(posedge clock) disable iff (reset)
      !(push && pop))
      else $error("stack pushed and popped together");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff != ST_IDLE && state_ff != ST_FINISH)
      else $error("register write outside execution");

endmodule
